// ===== rtl/bim_pkg.sv =====
`default_nettype none

package bim_pkg;

  // Depth of the word delay store
  localparam int unsigned DELAY_DEPTH_DEF = 16384;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG  = 2'd2;

  // Constellation codes; the unused code maps as 64-QAM
  localparam logic [1:0] CONS_QPSK  = 2'd0;
  localparam logic [1:0] CONS_16QAM = 2'd1;
  localparam logic [1:0] CONS_64QAM = 2'd2;

  localparam logic [1:0] MODE_RESET = 2'd3;
  localparam logic [3:0] SEG_RESET  = 4'd13;

  localparam int unsigned WORD_W = 6;
  localparam int unsigned ADJ_W  = 14;
  localparam int unsigned OUT_W  = 16;

  // Stored word: six raw bits, then bits pre-delayed by the base interleave delays.
  localparam int unsigned COPY_N = 13;
  localparam int unsigned COPY_W = 4;
  localparam int unsigned COPY_SRC  [COPY_N] = '{0, 1, 2, 3, 4, 5, 0, 1, 1, 2, 2, 3, 4};
  localparam int unsigned COPY_SKEW [COPY_N] =
    '{0, 0, 0, 0, 0, 0, 120, 80, 96, 40, 72, 48, 24};
  localparam int unsigned SL_LEN = 120;

  // Copy that feeds each index bit, per constellation (element 0 is index bit 0)
  typedef logic [WORD_W-1:0][COPY_W-1:0] sel_row_t;
  localparam sel_row_t SEL_QPSK  = {4'd5, 4'd4,  4'd3,  4'd2,  4'd1, 4'd6};
  localparam sel_row_t SEL_16QAM = {4'd5, 4'd4,  4'd3,  4'd9,  4'd7, 4'd6};
  localparam sel_row_t SEL_64QAM = {4'd5, 4'd12, 4'd11, 4'd10, 4'd8, 4'd6};

  // Q2.14 levels indexed by the Gray magnitude bits
  localparam logic signed [OUT_W-1:0] LVL_QPSK = 16'sd11585;
  localparam logic signed [OUT_W-1:0] LVL_16 [2] = '{16'sd15543, 16'sd5181};
  localparam logic signed [OUT_W-1:0] LVL_64 [4] =
    '{16'sd17697, 16'sd12641, 16'sd2528, 16'sd7584};

  typedef struct packed {
    logic [1:0]        cons;
    logic [ADJ_W-1:0]  adj;
    logic [COPY_N-1:0] sat;
  } cfg_t;

  // Adjustment delay in words: 192 * 2^(mode-1) * segments - 120, clamped at zero
  function automatic logic [ADJ_W-1:0] adj_of(input logic [1:0] mode, input logic [3:0] seg);
    logic [ADJ_W-1:0] prod;
    logic [ADJ_W-1:0] scaled;
    logic [ADJ_W:0]   diff;
    prod = ({10'd0, seg} << 7) + ({10'd0, seg} << 6);
    unique case (mode)
      2'd1:    scaled = prod;
      2'd2:    scaled = prod << 1;
      2'd3:    scaled = prod << 2;
      default: scaled = '0;
    endcase
    diff = {1'b0, scaled} - 15'd120;
    return diff[ADJ_W] ? '0 : diff[ADJ_W-1:0];
  endfunction

  // Copies whose total delay runs past the store take the oldest word instead
  function automatic logic [COPY_N-1:0] sat_of(input logic [ADJ_W-1:0] adj,
                                               input logic [16:0] depth_m1);
    logic [COPY_N-1:0] sat;
    for (int c = 0; c < COPY_N; c++) begin
      sat[c] = ({3'd0, adj} + 17'(COPY_SKEW[c])) > depth_m1;
    end
    return sat;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bit_interleave_qam_mapper.sv =====
// Bit interleaver and QAM mapper, one carrier word per request.
// Input channel: in_valid_i / in_ready_o with carrier_bits_i; the low 2, 4 or 6
// bits are used for QPSK, 16-QAM or 64-QAM. Each index bit comes from the word
// received a per-bit number of requests earlier (base interleave delay plus the
// adjustment delay set by mode and segment count).
// Output channel: out_valid_o / out_ready_i with in_phase_o and quadrature_o,
// signed Q2.14 constellation points, one result per request, in order.
// Config channel: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i selects
// constellation (0), transmission mode (1) or segment count (2); other indexes
// are dropped. Write only while no request is in flight.
// Pipeline: the delay store read is registered when a request is accepted, and
// the mapped point is registered when the store read stage moves on.
// Throughput: one request per cycle while out_ready_i stays high, limited by
// the single write port of the delay store (one write, two reads per request).
// Reset: configuration returns to QPSK, mode 3, 13 segments. The store needs no
// clearing pass: unwritten entries (by write pointer and full flag) read as zero.
// Stall: when out_ready_i is low, the result holds in the output register and
// one more request is taken into the store read stage; then in_ready_o drops.
`default_nettype none

module bit_interleave_qam_mapper #(
  parameter int unsigned DELAY_DEPTH = bim_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [bim_pkg::WORD_W-1:0]          carrier_bits_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [bim_pkg::OUT_W-1:0]         in_phase_o,
  output logic signed [bim_pkg::OUT_W-1:0]         quadrature_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [bim_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [bim_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  bim_pkg::cfg_t              cfg;
  logic                       accept;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_take;
  logic [bim_pkg::COPY_N-1:0] word_a;
  logic [bim_pkg::WORD_W-1:0] word_b;

  // Configuration registers and the derived adjustment delay
  bim_cfg #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Take a request whenever the store read stage is free or moving on
  assign in_ready_o = !s1_valid_q || s1_take;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_take) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Delay store: write the new word, read the delayed and the oldest word
  bim_store #(
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .carrier_bits_i(carrier_bits_i),
    .cfg_i         (cfg),
    .word_a_o      (word_a),
    .word_b_o      (word_b)
  );

  // Pick the index bits, look up the point, hold it for the receiver
  bim_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s1_valid_i  (s1_valid_q),
    .word_a_i    (word_a),
    .word_b_i    (word_b),
    .s1_take_o   (s1_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .in_phase_o  (in_phase_o),
    .quadrature_o(quadrature_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bim_cfg.sv =====
`default_nettype none

module bim_cfg #(
  parameter int unsigned DELAY_DEPTH = bim_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bim_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bim_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bim_pkg::cfg_t                         cfg_o
);

  localparam logic [16:0] DEPTH_M1 = 17'(DELAY_DEPTH - 1);

  logic [1:0]    mode_q, mode_d;
  logic [3:0]    seg_q, seg_d;
  logic [1:0]    cons_d;
  bim_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cons_d = cfg_q.cons;
    mode_d = mode_q;
    seg_d  = seg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bim_pkg::REG_CONS: cons_d = cfg_data_i[1:0];
        bim_pkg::REG_MODE: mode_d = cfg_data_i[1:0];
        bim_pkg::REG_SEG:  seg_d  = cfg_data_i[3:0];
        default: ;
      endcase
    end
    cfg_d.cons = cons_d;
    cfg_d.adj  = bim_pkg::adj_of(mode_d, seg_d);
    cfg_d.sat  = bim_pkg::sat_of(cfg_d.adj, DEPTH_M1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= bim_pkg::MODE_RESET;
      seg_q      <= bim_pkg::SEG_RESET;
      cfg_q.cons <= bim_pkg::CONS_QPSK;
      cfg_q.adj  <= bim_pkg::adj_of(bim_pkg::MODE_RESET, bim_pkg::SEG_RESET);
      cfg_q.sat  <= bim_pkg::sat_of(
                      bim_pkg::adj_of(bim_pkg::MODE_RESET, bim_pkg::SEG_RESET), DEPTH_M1);
    end else begin
      mode_q <= mode_d;
      seg_q  <= seg_d;
      cfg_q  <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bim_store.sv =====
`default_nettype none

module bim_store #(
  parameter int unsigned DELAY_DEPTH = bim_pkg::DELAY_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [bim_pkg::WORD_W-1:0]    carrier_bits_i,
  input  wire bim_pkg::cfg_t                 cfg_i,
  output logic [bim_pkg::COPY_N-1:0]         word_a_o,
  output logic [bim_pkg::WORD_W-1:0]         word_b_o
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CW = ((AW > bim_pkg::ADJ_W) ? AW : bim_pkg::ADJ_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

  logic [bim_pkg::WORD_W-1:0] sl_q [bim_pkg::SL_LEN];
  logic [bim_pkg::COPY_N-1:0] wr_word;
  logic [bim_pkg::COPY_N-1:0] mem [DELAY_DEPTH];

  logic [AW-1:0] wp_q, wp_d;
  logic          full_q, full_d;
  logic [CW-1:0] adj_w, dc_w;
  logic [AW-1:0] dc;
  logic [AW:0]   sum_a;
  logic [AW-1:0] addr_a, addr_b;
  logic          ok_a, ok_b, fwd_a;

  logic [bim_pkg::COPY_N-1:0] rd_a_q, fwd_word_q;
  logic [bim_pkg::WORD_W-1:0] rd_b_q;
  logic                       ok_a_q, ok_b_q, fwd_a_q;

  // Build the stored word: raw bits plus bits taken from the input history
  for (genvar c = 0; c < bim_pkg::COPY_N; c++) begin : g_copy
    localparam int unsigned S = bim_pkg::COPY_SKEW[c];
    localparam int unsigned B = bim_pkg::COPY_SRC[c];
    if (S == 0) begin : g_raw
      assign wr_word[c] = carrier_bits_i[B];
    end else begin : g_late
      assign wr_word[c] = sl_q[S-1][B];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bim_pkg::SL_LEN; i++) begin
        sl_q[i] <= '0;
      end
    end else if (accept_i) begin
      sl_q[0] <= carrier_bits_i;
      for (int i = 1; i < bim_pkg::SL_LEN; i++) begin
        sl_q[i] <= sl_q[i-1];
      end
    end
  end

  // Read addresses: adjustment delay back, and the oldest entry
  always_comb begin
    adj_w  = CW'(cfg_i.adj);
    dc_w   = (adj_w > CW'(DELAY_DEPTH - 1)) ? CW'(DELAY_DEPTH - 1) : adj_w;
    dc     = dc_w[AW-1:0];
    sum_a  = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, dc};
    addr_a = (sum_a >= (AW+1)'(DELAY_DEPTH)) ? AW'(sum_a - (AW+1)'(DELAY_DEPTH))
                                             : sum_a[AW-1:0];
    addr_b = (wp_q == LAST) ? '0 : wp_q + AW'(1);
    fwd_a  = (dc == '0);
    ok_a   = full_q || (addr_a < wp_q) || fwd_a;
    ok_b   = full_q || (addr_b < wp_q);
    wp_d   = wp_q;
    full_d = full_q;
    if (accept_i) begin
      wp_d = addr_b;
      if (wp_q == LAST) begin
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      full_q  <= 1'b0;
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
      fwd_a_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      full_q <= full_d;
      if (accept_i) begin
        ok_a_q  <= ok_a;
        ok_b_q  <= ok_b;
        fwd_a_q <= fwd_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[wp_q]  <= wr_word;
      rd_a_q     <= mem[addr_a];
      rd_b_q     <= mem[addr_b][bim_pkg::WORD_W-1:0];
      fwd_word_q <= wr_word;
    end
  end

  // Entries never written read as zero; a zero delay takes the word just written
  assign word_a_o = !ok_a_q ? '0 : (fwd_a_q ? fwd_word_q : rd_a_q);
  assign word_b_o = ok_b_q ? rd_b_q : '0;

endmodule

`default_nettype wire

// ===== rtl/bim_map.sv =====
`default_nettype none

module bim_map (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire bim_pkg::cfg_t                      cfg_i,
  input  wire logic                               s1_valid_i,
  input  wire logic [bim_pkg::COPY_N-1:0]         word_a_i,
  input  wire logic [bim_pkg::WORD_W-1:0]         word_b_i,
  output logic                                    s1_take_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [bim_pkg::OUT_W-1:0]        in_phase_o,
  output logic signed [bim_pkg::OUT_W-1:0]        quadrature_o
);

  logic [bim_pkg::COPY_N-1:0]        eff;
  bim_pkg::sel_row_t                 sel;
  logic [bim_pkg::WORD_W-1:0]        idx;
  logic signed [bim_pkg::OUT_W-1:0]  mag_i, mag_q, val_i, val_q;
  logic                              neg_i, neg_q;
  logic                              out_valid_q;
  logic signed [bim_pkg::OUT_W-1:0]  in_phase_q, quadrature_q;

  always_comb begin
    for (int c = 0; c < bim_pkg::COPY_N; c++) begin
      eff[c] = cfg_i.sat[c] ? word_b_i[bim_pkg::COPY_SRC[c]] : word_a_i[c];
    end
    unique case (cfg_i.cons)
      bim_pkg::CONS_QPSK:  sel = bim_pkg::SEL_QPSK;
      bim_pkg::CONS_16QAM: sel = bim_pkg::SEL_16QAM;
      default:             sel = bim_pkg::SEL_64QAM;
    endcase
    for (int b = 0; b < bim_pkg::WORD_W; b++) begin
      idx[b] = eff[sel[b]];
    end
  end

  // Top two index bits give the signs, the rest the Gray magnitude
  always_comb begin
    unique case (cfg_i.cons)
      bim_pkg::CONS_QPSK: begin
        mag_i = bim_pkg::LVL_QPSK;
        mag_q = bim_pkg::LVL_QPSK;
        neg_i = idx[1];
        neg_q = idx[0];
      end
      bim_pkg::CONS_16QAM: begin
        mag_i = bim_pkg::LVL_16[idx[1]];
        mag_q = bim_pkg::LVL_16[idx[0]];
        neg_i = idx[3];
        neg_q = idx[2];
      end
      default: begin
        mag_i = bim_pkg::LVL_64[{idx[3], idx[1]}];
        mag_q = bim_pkg::LVL_64[{idx[2], idx[0]}];
        neg_i = idx[5];
        neg_q = idx[4];
      end
    endcase
    val_i = neg_i ? -mag_i : mag_i;
    val_q = neg_q ? -mag_q : mag_q;
  end

  assign s1_take_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take_o) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take_o && s1_valid_i) begin
      in_phase_q   <= val_i;
      quadrature_q <= val_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_phase_o   = in_phase_q;
  assign quadrature_o = quadrature_q;

endmodule

`default_nettype wire
